FILE: sv/rmq_pkg.sv
package rmq_pkg;

  // Pipeline depths: one stage per root bit, one stage per quotient bit
  localparam int SqrtStages = 17;
  localparam int DivStages  = 31;
  localparam int RootW      = 17;
  localparam int RadW       = 17;
  localparam int MagW       = 17;
  localparam int NumW       = 31;

  typedef enum logic [1:0] {
    SEL_W = 2'd0,
    SEL_X = 2'd1,
    SEL_Y = 2'd2,
    SEL_Z = 2'd3
  } rmq_sel_e;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               degenerate;
  } rmq_out_t;

  // Branch, radicand and the three numerators, in component order skipping the branch
  typedef struct packed {
    rmq_sel_e                  sel;
    logic [RadW-1:0]           rad;
    logic [2:0]                neg;
    logic [2:0][MagW-1:0]      mag;
  } rmq_front_t;

  // Side data that rides along the divider stages
  typedef struct packed {
    rmq_sel_e    sel;
    logic        degen;
    logic [15:0] own;
  } rmq_info_t;

endpackage

FILE: sv/rmq_front.sv
module rmq_front import rmq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       vld_i,
  input  rmq_in_t    item_i,
  output logic       vld_o,
  output rmq_front_t front_o
);

  logic signed [18:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [18:0] tr, rad_s;
  logic signed [18:0] dv [3];
  rmq_front_t         front_d;
  rmq_front_t         front_q;
  logic               vld_q;

  assign e00 = 19'(item_i.r00);
  assign e01 = 19'(item_i.r01);
  assign e02 = 19'(item_i.r02);
  assign e10 = 19'(item_i.r10);
  assign e11 = 19'(item_i.r11);
  assign e12 = 19'(item_i.r12);
  assign e20 = 19'(item_i.r20);
  assign e21 = 19'(item_i.r21);
  assign e22 = 19'(item_i.r22);
  assign tr  = e00 + e11 + e22;

  // Branch pick, radicand and off-diagonal numerators
  always_comb begin
    front_d = '0;
    if (tr > 19'sd0) begin
      front_d.sel = SEL_W;
      rad_s = 19'sd16384 + tr;
      dv[0] = e21 - e12; dv[1] = e02 - e20; dv[2] = e10 - e01;
    end else if (e00 > e11 && e00 > e22) begin
      front_d.sel = SEL_X;
      rad_s = 19'sd16384 + e00 - e11 - e22;
      dv[0] = e21 - e12; dv[1] = e01 + e10; dv[2] = e02 + e20;
    end else if (e11 > e22) begin
      front_d.sel = SEL_Y;
      rad_s = 19'sd16384 + e11 - e00 - e22;
      dv[0] = e02 - e20; dv[1] = e01 + e10; dv[2] = e12 + e21;
    end else begin
      front_d.sel = SEL_Z;
      rad_s = 19'sd16384 + e22 - e00 - e11;
      dv[0] = e10 - e01; dv[1] = e02 + e20; dv[2] = e12 + e21;
    end
    // negative radicand clamps to zero
    front_d.rad = rad_s[18] ? '0 : rad_s[RadW-1:0];
    for (int j = 0; j < 3; j++) begin
      front_d.neg[j] = dv[j][18];
      front_d.mag[j] = dv[j][18] ? MagW'(-dv[j]) : MagW'(dv[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign vld_o   = vld_q;
  assign front_o = front_q;

endmodule

FILE: sv/rmq_sqrt.sv
module rmq_sqrt import rmq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  rmq_front_t       front_i,
  output logic             vld_o,
  output rmq_front_t       front_o,
  output logic [RootW-1:0] root_o
);

  logic [SqrtStages-1:0] vld_q;
  rmq_front_t            tag_q  [SqrtStages];
  logic [RootW-1:0]      root_q [SqrtStages];
  logic [17:0]           rem_q  [SqrtStages];

  // One root bit per stage, operand is rad << 16
  for (genvar s = 0; s < SqrtStages; s++) begin : g_stage
    localparam int P = SqrtStages - 1 - s;
    rmq_front_t       tag_p;
    logic [RootW-1:0] root_p, root_d;
    logic [17:0]      rem_p, rem_d;
    logic [19:0]      rem_sh, trial;
    logic [33:0]      n;
    logic             vld_p;

    if (s == 0) begin : g_first
      assign tag_p  = front_i;
      assign root_p = '0;
      assign rem_p  = '0;
      assign vld_p  = vld_i;
    end else begin : g_next
      assign tag_p  = tag_q[s-1];
      assign root_p = root_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign vld_p  = vld_q[s-1];
    end

    // remainder stays below 2^18 since it never exceeds twice the partial root
    always_comb begin
      n      = {1'b0, tag_p.rad, 16'b0};
      rem_sh = {rem_p, n[2*P+1 -: 2]};
      trial  = {1'b0, root_p, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = 18'(rem_sh - trial);
        root_d = {root_p[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[17:0];
        root_d = {root_p[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[s]  <= tag_p;
        root_q[s] <= root_d;
        rem_q[s]  <= rem_d;
      end
    end
  end

  assign vld_o   = vld_q[SqrtStages-1];
  assign front_o = tag_q[SqrtStages-1];
  assign root_o  = root_q[SqrtStages-1];

endmodule

FILE: sv/rmq_div.sv
module rmq_div import rmq_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [RootW-1:0] den_i,
  input  logic             neg_i,
  output logic [NumW-1:0]  quo_o,
  output logic             neg_o
);

  logic [NumW-1:0]  num_q [DivStages];
  logic [RootW-1:0] den_q [DivStages];
  logic [RootW-1:0] rem_q [DivStages];
  logic [NumW-1:0]  quo_q [DivStages];
  logic             neg_q [DivStages];

  // Restoring division, one quotient bit per stage, MSB first
  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    localparam int B = NumW - 1 - s;
    logic [NumW-1:0]  num_p, quo_p, quo_d;
    logic [RootW-1:0] den_p, rem_p, rem_d;
    logic [RootW:0]   rem_sh;
    logic             neg_p;

    if (s == 0) begin : g_first
      assign num_p = num_i;
      assign den_p = den_i;
      assign rem_p = '0;
      assign quo_p = '0;
      assign neg_p = neg_i;
    end else begin : g_next
      assign num_p = num_q[s-1];
      assign den_p = den_q[s-1];
      assign rem_p = rem_q[s-1];
      assign quo_p = quo_q[s-1];
      assign neg_p = neg_q[s-1];
    end

    always_comb begin
      rem_sh = {rem_p, num_p[B]};
      if (rem_sh >= {1'b0, den_p}) begin
        rem_d = RootW'(rem_sh - {1'b0, den_p});
        quo_d = {quo_p[NumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[RootW-1:0];
        quo_d = {quo_p[NumW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s] <= num_p;
        den_q[s] <= den_p;
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        neg_q[s] <= neg_p;
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];
  assign neg_o = neg_q[DivStages-1];

endmodule

FILE: sv/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to unit quaternion (Shepperd's method), signed Q2.14 in and out.
// Fully pipelined: one matrix is taken every cycle unless out_stall_i holds a result
// (1 decode stage, 17 square-root stages at one root bit each, 31 divider
// stages at one quotient bit each, 1 output register). out_stall_i freezes the
// whole pipeline while a result waits, and in_stall_o follows it. A zero divisor
// gives zero components with degenerate set; the three divided components
// saturate to 16 bits.
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rmq_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rmq_out_t out_item_o
);

  logic             en;
  logic             out_vld_q;
  rmq_out_t         out_q, out_d;

  logic             f_vld, s_vld;
  rmq_front_t       f_data, s_data;
  logic [RootW-1:0] root;
  logic [RootW:0]   own_sum;
  rmq_info_t        info_d;

  logic [DivStages-1:0] dvld_q;
  rmq_info_t            dinfo_q [DivStages];

  logic [NumW-1:0]  quo [3];
  logic             qneg [3];
  logic [15:0]      oth [3];

  // Whole pipeline advances unless a finished item is held
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (in_valid_i),
    .item_i  (in_item_i),
    .vld_o   (f_vld),
    .front_o (f_data)
  );

  rmq_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (f_vld),
    .front_i (f_data),
    .vld_o   (s_vld),
    .front_o (s_data),
    .root_o  (root)
  );

  // Branch component S/4 rounded half up
  assign own_sum     = {1'b0, root} + (RootW+1)'(2);
  assign info_d.sel   = s_data.sel;
  assign info_d.degen = (root == '0);
  assign info_d.own   = own_sum[RootW:2];

  // Three dividers: (mag * 16384 + root/2) / root
  for (genvar j = 0; j < 3; j++) begin : g_div
    logic [NumW-1:0] num;
    assign num = {s_data.mag[j], 14'b0} + NumW'(root[RootW-1:1]);

    rmq_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num),
      .den_i (root),
      .neg_i (s_data.neg[j]),
      .quo_o (quo[j]),
      .neg_o (qneg[j])
    );

    // Sign and saturate
    always_comb begin
      if (qneg[j]) begin
        oth[j] = (quo[j] > NumW'(32768)) ? 16'h8000 : 16'(-quo[j]);
      end else begin
        oth[j] = (quo[j] > NumW'(32767)) ? 16'h7fff : quo[j][15:0];
      end
    end
  end

  // Side data delay line matching the divider depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
    end else if (en) begin
      dvld_q <= {dvld_q[DivStages-2:0], s_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dinfo_q[0] <= info_d;
      for (int k = 1; k < DivStages; k++) begin
        dinfo_q[k] <= dinfo_q[k-1];
      end
    end
  end

  // Place components by branch
  always_comb begin
    out_d = '0;
    unique case (dinfo_q[DivStages-1].sel)
      SEL_W: begin
        out_d.quat_w = dinfo_q[DivStages-1].own;
        out_d.quat_x = oth[0]; out_d.quat_y = oth[1]; out_d.quat_z = oth[2];
      end
      SEL_X: begin
        out_d.quat_x = dinfo_q[DivStages-1].own;
        out_d.quat_w = oth[0]; out_d.quat_y = oth[1]; out_d.quat_z = oth[2];
      end
      SEL_Y: begin
        out_d.quat_y = dinfo_q[DivStages-1].own;
        out_d.quat_w = oth[0]; out_d.quat_x = oth[1]; out_d.quat_z = oth[2];
      end
      SEL_Z: begin
        out_d.quat_z = dinfo_q[DivStages-1].own;
        out_d.quat_w = oth[0]; out_d.quat_x = oth[1]; out_d.quat_y = oth[2];
      end
      default: out_d = '0;
    endcase
    if (dinfo_q[DivStages-1].degen) begin
      out_d = '0;
      out_d.degenerate = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dvld_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule
